// ----- rtl/assert_macros.svh -----
// assertion helpers, all checks run on the rising edge of clk and are off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))

`endif

// ----- rtl/mpvf_pkg.sv -----
`default_nettype none

package mpvf_pkg;

  // frame byte counter width
  localparam int LenW = 24;

  // input opcodes
  localparam logic [1:0] OpData  = 2'd0;
  localparam logic [1:0] OpFlush = 2'd1;
  localparam logic [1:0] OpEnd   = 2'd2;

  // start code values (byte after 00 00 01)
  localparam logic [7:0] ScPicture   = 8'h00;
  localparam logic [7:0] ScSliceLast = 8'haf;
  localparam logic [7:0] ScUser      = 8'hb2;
  localparam logic [7:0] ScSequence  = 8'hb3;
  localparam logic [7:0] ScExtension = 8'hb5;
  localparam logic [7:0] ScSeqEnd    = 8'hb7;
  localparam logic [7:0] ScGop       = 8'hb8;

  // sanitized defaults
  localparam logic [3:0] RateDefault   = 4'd3;
  localparam logic [3:0] AspectDefault = 4'd1;
  localparam logic [3:0] AspectMax     = 4'd14;
  localparam logic [3:0] RateMaxExt    = 4'd12;
  localparam logic [3:0] RateMaxBase   = 4'd8;

  // capture lengths in bytes after the code byte
  localparam logic [2:0] NeedSeq = 3'd4;
  localparam logic [2:0] NeedExt = 3'd7;
  localparam logic [2:0] NeedPic = 3'd2;

  // zero run: 0..2 zeros, 3 means prefix complete
  localparam logic [1:0] RunPrefix = 2'd3;
  localparam logic [2:0] HeadDone  = 3'd4;
  localparam logic [2:0] HeadCheck = 3'd3;

  typedef enum logic [1:0] {
    CapNone,
    CapSeq,
    CapExt,
    CapPic
  } cap_kind_t;

  // zero run tracker
  function automatic logic [1:0] next_run(input logic [1:0] run, input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (b == 8'h00) begin
      r = (run >= 2'd2) ? 2'd2 : run + 2'd1;
    end else if (b == 8'h01 && run >= 2'd2) begin
      r = RunPrefix;
    end
    return r;
  endfunction

  // codes accepted as the very first start code of a stream
  function automatic logic valid_head(input logic [7:0] c);
    return (c <= ScSliceLast) || (c == ScUser) || (c == ScSequence) ||
           (c == ScExtension) || (c == ScGop);
  endfunction

  // codes that sync the parser at any time
  function automatic logic sync_code(input logic [7:0] c);
    return (c == ScSequence) || (c == ScGop) || (c == ScExtension);
  endfunction

  // frame length up to the byte before the start code prefix
  function automatic logic [LenW-1:0] before_prefix(input logic [LenW-1:0] prev);
    logic [LenW-1:0] r;
    if (prev == '1) begin
      r = '1;
    end else if (prev >= LenW'(3)) begin
      r = prev - LenW'(3);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mpeg_video_picture_framer_core.sv -----
// MPEG-1/2 video picture framer.
// Input channel: in_valid/in_stall with opcode and data_byte; opcode 0 carries one
// stream byte, 1 is a flush or discontinuity, 2 is end of stream. A word is taken
// on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with one frame descriptor per finished picture
// (length, key flag and the header fields captured so far).
// cfg_write with cfg_data sets extended_rates (reset 1); write it only while idle.
// A byte that finishes a frame is taken into the input register; the edge on
// which it is processed updates state and loads the output register with its
// descriptor. Throughput is one byte per clock while no descriptor is held by
// out_stall: the whole per-byte state update is one combinational step from the input
// register to the state registers.
// Reset (rst, synchronous) clears the parser to unsynced, drops any frame and
// restores default header fields; the start-of-stream check is armed again.
// When out_stall holds a descriptor, the input register takes at most one more
// byte, then in_stall rises and the input register holds until the descriptor
// is taken.
`default_nettype none
`include "assert_macros.svh"

module mpeg_video_picture_framer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [7:0]                data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mpvf_pkg::LenW-1:0] frame_length,
  output logic                      key_frame,
  output logic [11:0]               picture_width,
  output logic [11:0]               picture_height,
  output logic [3:0]                aspect_code,
  output logic [3:0]                rate_code,
  output logic [1:0]                width_high_bits,
  output logic [1:0]                height_high_bits,
  output logic [1:0]                rate_ext_num,
  output logic [4:0]                rate_ext_den,
  output logic                      is_mpeg2,
  output logic                      headers_ready
);
  import mpvf_pkg::*;

  // input register
  logic       in_q_valid;
  logic [1:0] in_q_op;
  logic [7:0] in_q_byte;

  // parser state
  logic            extended_rates;
  logic [1:0]      zero_run, zero_run_next;
  logic            synced, synced_next;
  logic [2:0]      head_bytes, head_bytes_next;
  logic            picture_seen, picture_seen_next;
  logic [LenW-1:0] frame_bytes, frame_bytes_next;
  logic            frame_is_key, frame_is_key_next;
  cap_kind_t       cap_kind, cap_kind_next;
  logic [2:0]      cap_index, cap_index_next;
  logic [55:0]     cap_shift, cap_shift_next;
  logic [11:0]     seq_width, seq_width_next;
  logic [11:0]     seq_height, seq_height_next;
  logic [3:0]      seq_aspect, seq_aspect_next;
  logic [3:0]      seq_rate, seq_rate_next;
  logic [1:0]      ext_hx, ext_hx_next;
  logic [1:0]      ext_vx, ext_vx_next;
  logic [1:0]      ext_fn, ext_fn_next;
  logic [4:0]      ext_fd, ext_fd_next;
  logic            flag_seq, flag_seq_next;
  logic            flag_ext, flag_ext_next;

  // step results
  logic            emit;
  logic [LenW-1:0] emit_len;
  logic            emit_key;
  logic            proc_fire;
  logic            out_free;

  assign out_free  = !out_valid || !out_stall;
  assign proc_fire = in_q_valid && out_free;
  assign in_stall  = in_q_valid && !proc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_q_op   <= opcode;
      in_q_byte <= data_byte;
    end
  end

  // per-byte parser step
  always_comb begin
    logic            hit;
    logic            ps_e;
    logic            key_e;
    cap_kind_t       ck_e;
    logic [LenW-1:0] prev;
    logic [LenW-1:0] fb_inc;
    logic [55:0]     shift_new;
    logic [2:0]      idx_new;
    logic [2:0]      need;
    logic [3:0]      r_new;
    logic [3:0]      a_new;
    logic [3:0]      rmax;
    logic [7:0]      b;

    b         = in_q_byte;
    hit       = (zero_run == RunPrefix) &&
                (sync_code(b) || (head_bytes == HeadCheck && valid_head(b)));
    ps_e      = synced ? picture_seen : 1'b0;
    key_e     = synced ? frame_is_key : 1'b0;
    ck_e      = synced ? cap_kind : CapNone;
    prev      = synced ? frame_bytes : LenW'(3);
    fb_inc    = (prev == '1) ? prev : prev + LenW'(1);
    shift_new = {cap_shift[47:0], b};
    idx_new   = cap_index + 3'd1;
    case (ck_e)
      CapSeq:  need = NeedSeq;
      CapExt:  need = NeedExt;
      default: need = NeedPic;
    endcase
    rmax  = extended_rates ? RateMaxExt : RateMaxBase;
    r_new = shift_new[3:0];
    if (r_new < 4'd1 || r_new > rmax) begin
      r_new = RateDefault;
    end
    a_new = shift_new[7:4];
    if (a_new < 4'd1 || a_new > AspectMax) begin
      a_new = AspectDefault;
    end

    zero_run_next     = zero_run;
    synced_next       = synced;
    head_bytes_next   = head_bytes;
    picture_seen_next = picture_seen;
    frame_bytes_next  = frame_bytes;
    frame_is_key_next = frame_is_key;
    cap_kind_next     = cap_kind;
    cap_index_next    = cap_index;
    cap_shift_next    = cap_shift;
    seq_width_next    = seq_width;
    seq_height_next   = seq_height;
    seq_aspect_next   = seq_aspect;
    seq_rate_next     = seq_rate;
    ext_hx_next       = ext_hx;
    ext_vx_next       = ext_vx;
    ext_fn_next       = ext_fn;
    ext_fd_next       = ext_fd;
    flag_seq_next     = flag_seq;
    flag_ext_next     = flag_ext;
    emit              = 1'b0;
    emit_len          = before_prefix(prev);
    emit_key          = key_e;

    if (proc_fire) begin
      case (in_q_op)
        OpFlush, OpEnd: begin
          zero_run_next     = 2'd0;
          synced_next       = 1'b0;
          head_bytes_next   = HeadDone;
          picture_seen_next = 1'b0;
          frame_bytes_next  = '0;
          frame_is_key_next = 1'b0;
          cap_kind_next     = CapNone;
          cap_index_next    = 3'd0;
          cap_shift_next    = '0;
        end
        OpData: begin
          if (!synced && head_bytes < HeadDone) begin
            head_bytes_next = head_bytes + 3'd1;
          end
          if (!synced && !hit) begin
            // hunting for a sync code
            zero_run_next = (zero_run == RunPrefix) ? {1'b0, b == 8'h00}
                                                    : next_run(zero_run, b);
          end else begin
            synced_next       = 1'b1;
            picture_seen_next = ps_e;
            frame_is_key_next = key_e;
            cap_kind_next     = ck_e;
            frame_bytes_next  = fb_inc;
            if (zero_run == RunPrefix) begin
              // code byte
              zero_run_next  = {1'b0, b == 8'h00};
              cap_kind_next  = CapNone;
              cap_index_next = 3'd0;
              cap_shift_next = '0;
              case (b)
                ScPicture: begin
                  if (ps_e) begin
                    emit             = 1'b1;
                    frame_bytes_next = LenW'(4);
                  end
                  picture_seen_next = 1'b1;
                  frame_is_key_next = 1'b0;
                  cap_kind_next     = CapPic;
                end
                ScSequence, ScGop, ScExtension: begin
                  if (ps_e) begin
                    emit              = 1'b1;
                    frame_bytes_next  = LenW'(4);
                    picture_seen_next = 1'b0;
                    frame_is_key_next = 1'b0;
                  end
                  if (b == ScSequence) begin
                    cap_kind_next = CapSeq;
                  end else if (b == ScExtension) begin
                    cap_kind_next = CapExt;
                  end
                end
                ScSeqEnd: begin
                  if (ps_e) begin
                    emit              = 1'b1;
                    emit_len          = fb_inc;
                    frame_bytes_next  = '0;
                    picture_seen_next = 1'b0;
                    frame_is_key_next = 1'b0;
                    synced_next       = 1'b0;
                    zero_run_next     = 2'd0;
                  end
                end
                default: ;
              endcase
            end else begin
              // header capture
              if (ck_e != CapNone) begin
                cap_shift_next = shift_new;
                cap_index_next = idx_new;
                if (idx_new >= need) begin
                  cap_kind_next  = CapNone;
                  cap_index_next = 3'd0;
                  case (ck_e)
                    CapSeq: begin
                      seq_width_next  = shift_new[31:20];
                      seq_height_next = shift_new[19:8];
                      seq_aspect_next = a_new;
                      seq_rate_next   = r_new;
                      flag_seq_next   = 1'b1;
                    end
                    CapExt: begin
                      if (shift_new[55:52] == 4'd1) begin
                        ext_hx_next   = shift_new[40:39];
                        ext_vx_next   = shift_new[38:37];
                        ext_fn_next   = shift_new[14:13];
                        ext_fd_next   = shift_new[12:8];
                        flag_ext_next = 1'b1;
                      end
                    end
                    default: begin
                      frame_is_key_next = (b[5:3] == 3'd1);
                    end
                  endcase
                end
              end
              zero_run_next = next_run(zero_run, b);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      extended_rates <= 1'b1;
      zero_run       <= 2'd0;
      synced         <= 1'b0;
      head_bytes     <= 3'd0;
      picture_seen   <= 1'b0;
      frame_bytes    <= '0;
      frame_is_key   <= 1'b0;
      cap_kind       <= CapNone;
      cap_index      <= 3'd0;
      cap_shift      <= '0;
      seq_width      <= '0;
      seq_height     <= '0;
      seq_aspect     <= AspectDefault;
      seq_rate       <= RateDefault;
      ext_hx         <= '0;
      ext_vx         <= '0;
      ext_fn         <= '0;
      ext_fd         <= '0;
      flag_seq       <= 1'b0;
      flag_ext       <= 1'b0;
    end else begin
      if (cfg_write) begin
        extended_rates <= cfg_data;
      end
      zero_run     <= zero_run_next;
      synced       <= synced_next;
      head_bytes   <= head_bytes_next;
      picture_seen <= picture_seen_next;
      frame_bytes  <= frame_bytes_next;
      frame_is_key <= frame_is_key_next;
      cap_kind     <= cap_kind_next;
      cap_index    <= cap_index_next;
      cap_shift    <= cap_shift_next;
      seq_width    <= seq_width_next;
      seq_height   <= seq_height_next;
      seq_aspect   <= seq_aspect_next;
      seq_rate     <= seq_rate_next;
      ext_hx       <= ext_hx_next;
      ext_vx       <= ext_vx_next;
      ext_fn       <= ext_fn_next;
      ext_fd       <= ext_fd_next;
      flag_seq     <= flag_seq_next;
      flag_ext     <= flag_ext_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc_fire && emit;
    end
    if (proc_fire && emit) begin
      frame_length     <= emit_len;
      key_frame        <= emit_key;
      picture_width    <= seq_width;
      picture_height   <= seq_height;
      aspect_code      <= seq_aspect;
      rate_code        <= seq_rate;
      width_high_bits  <= ext_hx;
      height_high_bits <= ext_vx;
      rate_ext_num     <= ext_fn;
      rate_ext_den     <= ext_fd;
      is_mpeg2         <= flag_ext;
      headers_ready    <= flag_seq;
    end
  end

  // checks
  `ASSERT_NEVER(a_unsynced_no_picture, !synced && picture_seen)
  `ASSERT_NEVER(a_idle_capture_index, cap_kind == CapNone && cap_index != 3'd0)
  `ASSERT_CLK(a_emit_reaches_output, proc_fire && emit |=> out_valid)
  `ASSERT_CLK(a_seq_flag_sticky, flag_seq |=> flag_seq)

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mpvf_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 500;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [3:0] ExtIdSequence = 4'd1;
  localparam logic [2:0] PicTypeIntra = 3'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } word_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic key;
    logic [11:0] w;
    logic [11:0] h;
    logic [3:0] asp;
    logic [3:0] rate;
    logic [1:0] hx;
    logic [1:0] vx;
    logic [1:0] fn;
    logic [4:0] fd;
    logic mpeg2;
    logic ready;
  } frame_t;

  // tracks the parser state and the frame descriptors it should produce
  class frame_tracker;
    bit ext_rates;
    logic [1:0] zrun;
    bit synced;
    logic [2:0] head_cnt;
    bit pic_open;
    logic [LenW-1:0] fbytes;
    bit fkey;
    cap_kind_t cap;
    logic [2:0] cap_idx;
    logic [55:0] cap_sh;
    logic [11:0] seq_w, seq_h;
    logic [3:0] seq_asp, seq_rate;
    logic [1:0] ext_hx, ext_vx, ext_fn;
    logic [4:0] ext_fd;
    bit have_seq, have_ext;
    frame_t pending_frames[$];
    int mismatches;

    function new();
      ext_rates = 1'b1;
      head_cnt = 3'd0;
      clear_parse();
      seq_w = '0;
      seq_h = '0;
      seq_asp = AspectDefault;
      seq_rate = RateDefault;
      ext_hx = '0;
      ext_vx = '0;
      ext_fn = '0;
      ext_fd = '0;
      have_seq = 1'b0;
      have_ext = 1'b0;
      mismatches = 0;
    endfunction

    function void set_capture(cap_kind_t kind);
      cap = kind;
      cap_idx = '0;
      cap_sh = '0;
    endfunction

    function void clear_parse();
      zrun = '0;
      synced = 1'b0;
      pic_open = 1'b0;
      fbytes = '0;
      fkey = 1'b0;
      set_capture(CapNone);
    endfunction

    function logic [1:0] run_after(logic [1:0] run, logic [7:0] b);
      if (b == 8'h00) return (run >= 2'd2) ? 2'd2 : run + 2'd1;
      if (b == 8'h01 && run >= 2'd2) return RunPrefix;
      return 2'd0;
    endfunction

    function void push_frame(logic [LenW-1:0] len);
      frame_t f;
      f.len = len;
      f.key = fkey;
      f.w = seq_w;
      f.h = seq_h;
      f.asp = seq_asp;
      f.rate = seq_rate;
      f.hx = ext_hx;
      f.vx = ext_vx;
      f.fn = ext_fn;
      f.fd = ext_fd;
      f.mpeg2 = have_ext;
      f.ready = have_seq;
      pending_frames.push_back(f);
    endfunction

    // advance the parser by one accepted word
    function void take_word(logic [1:0] op, logic [7:0] b);
      logic [LenW-1:0] prev, cut;
      bit hit;
      logic [3:0] a, r, rmax;
      logic [2:0] need;
      if (op == OpFlush || op == OpEnd) begin
        clear_parse();
        head_cnt = HeadDone;
        return;
      end
      if (op != OpData) return;

      // hunting for a sync code, with the start-of-stream shortcut
      if (!synced) begin
        hit = 1'b0;
        if (zrun == RunPrefix) begin
          hit = (b == ScSequence) || (b == ScGop) || (b == ScExtension) ||
                (head_cnt == HeadCheck && (b <= ScSliceLast || b == ScUser));
        end
        if (head_cnt < HeadDone) head_cnt++;
        if (!hit) begin
          if (zrun == RunPrefix) zrun = (b == 8'h00) ? 2'd1 : 2'd0;
          else zrun = run_after(zrun, b);
          return;
        end
        synced = 1'b1;
        fbytes = LenW'(3);
        pic_open = 1'b0;
        fkey = 1'b0;
        set_capture(CapNone);
      end

      prev = fbytes;
      if (fbytes != '1) fbytes++;

      // code byte right after a prefix
      if (zrun == RunPrefix) begin
        zrun = (b == 8'h00) ? 2'd1 : 2'd0;
        if (prev == '1) cut = '1;
        else if (prev >= LenW'(3)) cut = prev - LenW'(3);
        else cut = '0;
        case (b)
          ScPicture: begin
            if (pic_open) begin
              push_frame(cut);
              fbytes = LenW'(4);
            end
            pic_open = 1'b1;
            fkey = 1'b0;
            set_capture(CapPic);
          end
          ScSequence, ScGop, ScExtension: begin
            if (pic_open) begin
              push_frame(cut);
              fbytes = LenW'(4);
              pic_open = 1'b0;
              fkey = 1'b0;
            end
            if (b == ScSequence) set_capture(CapSeq);
            else if (b == ScExtension) set_capture(CapExt);
            else set_capture(CapNone);
          end
          ScSeqEnd: begin
            set_capture(CapNone);
            if (pic_open) begin
              push_frame(fbytes);
              fbytes = '0;
              pic_open = 1'b0;
              fkey = 1'b0;
              synced = 1'b0;
              zrun = '0;
            end
          end
          default: set_capture(CapNone);
        endcase
        return;
      end

      // header capture
      if (cap != CapNone) begin
        cap_sh = {cap_sh[47:0], b};
        cap_idx++;
        if (cap == CapSeq) need = NeedSeq;
        else if (cap == CapExt) need = NeedExt;
        else need = NeedPic;
        if (cap_idx >= need) begin
          case (cap)
            CapSeq: begin
              a = cap_sh[7:4];
              r = cap_sh[3:0];
              rmax = ext_rates ? RateMaxExt : RateMaxBase;
              if (r < 4'd1 || r > rmax) r = RateDefault;
              if (a < 4'd1 || a > AspectMax) a = AspectDefault;
              seq_w = cap_sh[31:20];
              seq_h = cap_sh[19:8];
              seq_asp = a;
              seq_rate = r;
              have_seq = 1'b1;
            end
            CapExt: begin
              if (cap_sh[55:52] == ExtIdSequence) begin
                ext_hx = cap_sh[40:39];
                ext_vx = cap_sh[38:37];
                ext_fn = cap_sh[14:13];
                ext_fd = cap_sh[12:8];
                have_ext = 1'b1;
              end
            end
            default: fkey = (b[5:3] == PicTypeIntra);
          endcase
          set_capture(CapNone);
        end
      end
      zrun = run_after(zrun, b);
    endfunction

    function string show(frame_t f);
      return $sformatf({"len=%0d key=%0d w=%0d h=%0d asp=%0d rate=%0d hx=%0d vx=%0d ",
                        "fn=%0d fd=%0d mpeg2=%0d ready=%0d"},
                       f.len, f.key, f.w, f.h, f.asp, f.rate, f.hx, f.vx, f.fn, f.fd,
                       f.mpeg2, f.ready);
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // compare a descriptor from the block with the oldest expected one
    function void check_frame(frame_t got);
      frame_t want;
      string bad;
      if (pending_frames.size() == 0) begin
        note_error({"descriptor with none expected: ", show(got)});
        return;
      end
      want = pending_frames.pop_front();
      bad = "";
      if (got.len !== want.len) bad = {bad, " frame_length"};
      if (got.key !== want.key) bad = {bad, " key_frame"};
      if (got.w !== want.w) bad = {bad, " picture_width"};
      if (got.h !== want.h) bad = {bad, " picture_height"};
      if (got.asp !== want.asp) bad = {bad, " aspect_code"};
      if (got.rate !== want.rate) bad = {bad, " rate_code"};
      if (got.hx !== want.hx) bad = {bad, " width_high_bits"};
      if (got.vx !== want.vx) bad = {bad, " height_high_bits"};
      if (got.fn !== want.fn) bad = {bad, " rate_ext_num"};
      if (got.fd !== want.fd) bad = {bad, " rate_ext_den"};
      if (got.mpeg2 !== want.mpeg2) bad = {bad, " is_mpeg2"};
      if (got.ready !== want.ready) bad = {bad, " headers_ready"};
      if (bad != "") begin
        note_error({"bad", bad, "\n  expected ", show(want), "\n  actual   ", show(got)});
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic out_valid;
  logic out_stall;
  logic [LenW-1:0] frame_length;
  logic key_frame;
  logic [11:0] picture_width;
  logic [11:0] picture_height;
  logic [3:0] aspect_code;
  logic [3:0] rate_code;
  logic [1:0] width_high_bits;
  logic [1:0] height_high_bits;
  logic [1:0] rate_ext_num;
  logic [4:0] rate_ext_den;
  logic is_mpeg2;
  logic headers_ready;

  frame_tracker tracker;
  word_t word_feed[$];
  bit quiet;
  bit hold_req;
  bit hold_done;
  int cycle_count;

  mpeg_video_picture_framer_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .frame_length     (frame_length),
    .key_frame        (key_frame),
    .picture_width    (picture_width),
    .picture_height   (picture_height),
    .aspect_code      (aspect_code),
    .rate_code        (rate_code),
    .width_high_bits  (width_high_bits),
    .height_high_bits (height_high_bits),
    .rate_ext_num     (rate_ext_num),
    .rate_ext_den     (rate_ext_den),
    .is_mpeg2         (is_mpeg2),
    .headers_ready    (headers_ready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_stall = !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  // descriptor monitor
  always @(posedge clk) begin : watch_frames
    frame_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.len = frame_length;
      got.key = key_frame;
      got.w = picture_width;
      got.h = picture_height;
      got.asp = aspect_code;
      got.rate = rate_code;
      got.hx = width_high_bits;
      got.vx = height_high_bits;
      got.fn = rate_ext_num;
      got.fd = rate_ext_den;
      got.mpeg2 = is_mpeg2;
      got.ready = headers_ready;
      tracker.check_frame(got);
    end
  end

  // stream building
  function void add(logic [1:0] op, logic [7:0] b);
    word_t w;
    w.op = op;
    w.b = b;
    word_feed.push_back(w);
  endfunction

  function logic [7:0] stream_byte();
    return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
  endfunction

  function void add_bytes(int n);
    for (int k = 0; k < n; k++) add(OpData, stream_byte());
  endfunction

  // start code, sometimes with an extra leading zero
  function void add_code(logic [7:0] c);
    if ($urandom_range(7) == 0) add(OpData, 8'h00);
    add(OpData, 8'h00);
    add(OpData, 8'h00);
    add(OpData, 8'h01);
    add(OpData, c);
  endfunction

  function void add_seq();
    logic [31:0] hdr;
    int n;
    hdr = $urandom;
    if ($urandom_range(5) == 0) hdr[31:8] = $urandom_range(1) ? 24'h000000 : 24'hffffff;
    add_code(ScSequence);
    n = ($urandom_range(7) == 0) ? $urandom_range(0, 3) : 4;
    for (int k = 0; k < n; k++) add(OpData, hdr[31 - 8 * k -: 8]);
    add_bytes($urandom_range(0, 4));
  endfunction

  function void add_ext();
    logic [55:0] body;
    int n;
    body = 56'({$urandom, $urandom});
    body[55:52] = ($urandom_range(4) == 0) ? 4'($urandom) : ExtIdSequence;
    add_code(ScExtension);
    n = ($urandom_range(7) == 0) ? $urandom_range(0, 6) : 7;
    for (int k = 0; k < n; k++) add(OpData, body[55 - 8 * k -: 8]);
    add_bytes($urandom_range(0, 3));
  endfunction

  function void add_gop();
    add_code(ScGop);
    add_bytes(4);
  endfunction

  function void add_picture();
    int hdr_len, slices;
    logic [2:0] ptype;
    add_code(ScPicture);
    hdr_len = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : 2;
    if (hdr_len > 0) add(OpData, 8'($urandom));
    if (hdr_len > 1) begin
      ptype = ($urandom_range(7) < 6) ? 3'($urandom_range(1, 3)) : 3'($urandom);
      add(OpData, {2'($urandom), ptype, 3'($urandom)});
    end
    slices = $urandom_range(0, 3);
    for (int k = 0; k < slices; k++) begin
      if ($urandom_range(4) == 0) add_code(ScUser);
      else add_code(8'($urandom_range(1, ScSliceLast)));
      add_bytes($urandom_range(0, 12));
    end
    if (slices == 0) add_bytes($urandom_range(0, 6));
  endfunction

  // one well-formed sequence with random content, sometimes with noise
  function void add_stream();
    int pics, n;
    if ($urandom_range(4) == 0) begin
      n = $urandom_range(1, 10);
      add_bytes(n);
      if ($urandom_range(1)) begin
        // prefix whose code byte does not follow it directly
        add(OpData, 8'h00);
        add(OpData, 8'h00);
        add(OpData, 8'h01);
        add(OpData, 8'h00);
        add(OpData, ScSequence);
      end
    end
    case ($urandom_range(5))
      0: add_gop();
      1: add_ext();
      default: add_seq();
    endcase
    if ($urandom_range(1)) add_ext();
    if ($urandom_range(1)) add_gop();
    pics = $urandom_range(1, 6);
    for (int k = 0; k < pics; k++) begin
      if ($urandom_range(9) == 0) add_seq();
      else if ($urandom_range(9) == 0) add_ext();
      else if ($urandom_range(9) == 0) add_gop();
      add_picture();
    end
    case ($urandom_range(9))
      0: add(OpFlush, 8'($urandom));
      1: add(OpEnd, 8'($urandom));
      2: add(OpUnused, 8'($urandom));
      3, 4, 5: add_code(ScSeqEnd);
      default: ;
    endcase
    // sequence end with no picture held
    if ($urandom_range(15) == 0) begin
      add_seq();
      add_code(ScSeqEnd);
    end
  endfunction

  // sender
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    tracker.take_word(op, b);
  endtask

  task automatic send_feed();
    word_t w;
    while (word_feed.size() != 0) begin
      w = word_feed.pop_front();
      send_word(w.op, w.b);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic run_random(input int words);
    while (word_feed.size() < words) add_stream();
    send_feed();
  endtask

  // wait for every expected descriptor, then let the pipeline empty
  task automatic settle();
    while (tracker.pending_frames.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_rates(input logic v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.ext_rates = v;
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    opcode = OpData;
    data_byte = 8'h00;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // stream opening on a picture code, intra picture
    add(OpData, 8'h00);
    add(OpData, 8'h00);
    add(OpData, 8'h01);
    add(OpData, ScPicture);
    add(OpData, 8'h48);
    add(OpData, 8'h08);
    // sequence header ends the frame, all-ones fields get sanitized
    add(OpData, 8'h00);
    add(OpData, 8'h00);
    add(OpData, 8'h01);
    add(OpData, ScSequence);
    add(OpData, 8'hff);
    add(OpData, 8'hff);
    add(OpData, 8'hff);
    add(OpData, 8'hff);
    // picture cut short by a sequence end
    add_code(ScPicture);
    add_code(ScSeqEnd);
    // broken prefix while unsynced, then the non-data opcodes
    add(OpData, 8'h00);
    add(OpData, 8'h00);
    add(OpData, 8'h01);
    add(OpData, 8'h00);
    add(OpData, ScSequence);
    add(OpUnused, 8'hff);
    add(OpFlush, 8'h00);
    add(OpEnd, 8'hff);
    send_feed();
    settle();

    // random phases over both rate settings
    set_rates(1'b0);
    quiet = 1'b1;
    run_random(450);
    settle();
    quiet = 1'b0;
    set_rates(1'b1);
    hold_req = 1'b1;
    run_random(450);
    settle();
    set_rates(1'b0);
    run_random(450);
    settle();
    set_rates(1'b1);
    run_random(450);
    settle();

    if (tracker.mismatches == 0 && tracker.pending_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
